/* rtl/ppdf_pkg.sv */
`timescale 1ns / 1ps

package ppdf_pkg;

    localparam int COORD_W    = 32;
    localparam int TOL_W      = 31;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 64;
    localparam int ORD_W      = 10;
    localparam int PART_W     = 8;
    localparam int INDEX_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    // RAM read, x/y/z stagger and three cell stages
    localparam int PIPE_LAT   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Z   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [TOL_W-1:0]          t_tol;
    typedef logic [ORD_W-1:0]          t_ordinal;

    typedef enum logic [1:0] {
        ST_KEPT      = 2'd0,
        ST_OFF_PLANE = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // partial distance handed from cell to cell
    typedef struct packed {
        logic             far;
        logic [SUM_W-1:0] sum;
    } t_partial;

    function automatic logic [COORD_W-1:0] abs_diff(t_coord a, t_coord b);
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] nd;
        d  = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        nd = -d;
        return d[COORD_W] ? nd[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

endpackage

/* rtl/ppdf_pt_if.sv */
`timescale 1ns / 1ps

interface ppdf_pt_if;
    logic                   valid;
    logic                   ready;
    logic                   start_cloud;
    ppdf_pkg::t_coord       coord_x;
    ppdf_pkg::t_coord       coord_y;
    ppdf_pkg::t_coord       coord_z;
    logic [ppdf_pkg::PART_W-1:0]  source_part;
    logic [ppdf_pkg::INDEX_W-1:0] local_index;

    modport source (
        output valid, start_cloud, coord_x, coord_y, coord_z, source_part, local_index,
        input  ready
    );
    modport sink (
        input  valid, start_cloud, coord_x, coord_y, coord_z, source_part, local_index,
        output ready
    );
endinterface

/* rtl/ppdf_res_if.sv */
`timescale 1ns / 1ps

interface ppdf_res_if;
    logic                         valid;
    logic                         ready;
    ppdf_pkg::t_status            status;
    ppdf_pkg::t_ordinal           kept_ordinal;
    logic [ppdf_pkg::PART_W-1:0]  out_part;
    logic [ppdf_pkg::INDEX_W-1:0] out_index;

    modport source (
        output valid, status, kept_ordinal, out_part, out_index,
        input  ready
    );
    modport sink (
        input  valid, status, kept_ordinal, out_part, out_index,
        output ready
    );
endinterface

/* rtl/ppdf_ram.sv */
`timescale 1ns / 1ps

module ppdf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ppdf_cell.sv */
`timescale 1ns / 1ps

// One axis of the distance chain: |a-b|, its square, then add to the neighbor's sum.
// The incoming partial is added once the coordinates have passed the difference and square registers.
module ppdf_cell (
    input  logic               i_clk,
    input  ppdf_pkg::t_coord   i_stored,
    input  ppdf_pkg::t_coord   i_probe,
    input  ppdf_pkg::t_tol     i_tol,
    input  ppdf_pkg::t_partial i_part,
    output ppdf_pkg::t_partial o_part
);

    logic [ppdf_pkg::COORD_W-1:0] w_d;
    logic [ppdf_pkg::TOL_W-1:0]   r_d;
    logic                         r_far1;
    logic                         r_far2;
    logic [ppdf_pkg::SQ_W-1:0]    r_sq;
    ppdf_pkg::t_partial           r_part;

    assign w_d = ppdf_pkg::abs_diff(i_stored, i_probe);

    always_ff @(posedge i_clk) begin
        r_d        <= w_d[ppdf_pkg::TOL_W-1:0];
        r_far1     <= (w_d >= {1'b0, i_tol});
        r_sq       <= r_d * r_d;
        r_far2     <= r_far1;
        r_part.far <= i_part.far | r_far2;
        r_part.sum <= i_part.sum + {2'b00, r_sq};
    end

    assign o_part = r_part;

endmodule

/* rtl/plane_point_dedup_filter.sv */
`timescale 1ns / 1ps

// Plane point dedup filter. Takes one Q16.16 point per transaction on i_pt and returns one
// status transaction on o_res: kept (with a running ordinal), off plane, duplicate, or store
// full. A point is off plane when |z - plane_z| exceeds match_tolerance; otherwise it is a
// duplicate when its squared distance to any earlier stored point (kept or not) is strictly
// below match_tolerance squared, computed exactly. Every point except a store-full one is
// appended to the store; start_cloud empties the store and the kept count first. Items are
// handled one at a time: a point that reaches the duplicate scan is compared with all N points
// already stored, since the store RAM delivers one stored point per cycle into the three-cell
// distance chain; off-plane points and the first point of a cloud skip the scan, and store-full
// points skip both tests. A finished result sits in the output register, so the next point is
// accepted while it waits. Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) apply at once
// and belong to idle periods.
module plane_point_dedup_filter #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppdf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppdf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ppdf_pt_if.sink                            i_pt,
    ppdf_res_if.source                         o_res
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = $bits(ppdf_pkg::t_point);

    // configuration
    ppdf_pkg::t_coord              r_plane_z;
    ppdf_pkg::t_tol                r_tol;
    logic [ppdf_pkg::SQ_W-1:0]     r_tol_sq;

    // control
    ppdf_pkg::t_state              r_state;
    ppdf_pkg::t_state              n_state;
    logic [CW-1:0]                 r_seen;
    logic [CW-1:0]                 r_kept;
    logic [AW-1:0]                 r_addr;
    logic [ppdf_pkg::PIPE_LAT-1:0] r_vld;
    logic                          r_dup;
    logic                          r_off;
    logic                          r_out_valid;

    // current point and its result
    ppdf_pkg::t_point              r_probe;
    logic [ppdf_pkg::PART_W-1:0]   r_part;
    logic [ppdf_pkg::INDEX_W-1:0]  r_index;
    ppdf_pkg::t_status             r_status;
    ppdf_pkg::t_ordinal            r_ordinal;

    // output register
    ppdf_pkg::t_status             r_out_status;
    ppdf_pkg::t_ordinal            r_out_ord;
    logic [ppdf_pkg::PART_W-1:0]   r_out_part;
    logic [ppdf_pkg::INDEX_W-1:0]  r_out_index;

    // strobes from the state machine
    logic w_in_ready;
    logic w_issue;
    logic w_commit;
    logic w_load_out;

    logic w_accept;
    logic w_full;
    logic w_off;
    logic w_last;
    logic w_hit;

    logic [PW-1:0]         w_rdata;
    ppdf_pkg::t_point      w_stored_pt;
    ppdf_pkg::t_coord      r_y_d1;
    ppdf_pkg::t_coord      r_z_d1;
    ppdf_pkg::t_coord      r_z_d2;
    ppdf_pkg::t_coord      w_stored [3];
    ppdf_pkg::t_coord      w_probe  [3];
    ppdf_pkg::t_partial    w_chain  [4];

    assign w_accept = i_pt.valid & w_in_ready;
    assign w_full   = (r_seen == CW'(MAX_POINTS));
    assign w_off    = ppdf_pkg::abs_diff(r_probe.z, r_plane_z) > {1'b0, r_tol};
    assign w_last   = ((CW'(r_addr) + CW'(1)) == r_seen);
    assign w_hit    = !w_chain[3].far && (w_chain[3].sum < {2'b00, r_tol_sq});

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppdf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_commit   = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ppdf_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_pt.valid) begin
                    n_state = ppdf_pkg::S_CHECK;
                end
            end
            ppdf_pkg::S_CHECK: begin
                // store full skips the tests; off plane or empty store skips the scan
                if (w_full) begin
                    n_state = ppdf_pkg::S_FINISH;
                end else if (w_off || (r_seen == '0)) begin
                    n_state = ppdf_pkg::S_COMMIT;
                end else begin
                    n_state = ppdf_pkg::S_SCAN;
                end
            end
            ppdf_pkg::S_SCAN: begin
                w_issue = 1'b1;
                if (w_last) begin
                    n_state = ppdf_pkg::S_DRAIN;
                end
            end
            ppdf_pkg::S_DRAIN: begin
                // wait for the last stored point to leave the chain
                if (r_vld == '0) begin
                    n_state = ppdf_pkg::S_COMMIT;
                end
            end
            ppdf_pkg::S_COMMIT: begin
                w_commit = 1'b1;
                n_state  = ppdf_pkg::S_FINISH;
            end
            ppdf_pkg::S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ppdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppdf_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control and configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_z   <= '0;
            r_tol       <= ppdf_pkg::TOL_RESET;
            r_seen      <= '0;
            r_kept      <= '0;
            r_vld       <= '0;
            r_dup       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ppdf_pkg::CFG_PLANE_Z:   r_plane_z <= i_cfg_data;
                    ppdf_pkg::CFG_MATCH_TOL: r_tol     <= i_cfg_data[ppdf_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end

            r_vld <= {r_vld[ppdf_pkg::PIPE_LAT-2:0], w_issue};

            // drop the store and the kept count before this point
            if (w_accept && i_pt.start_cloud) begin
                r_seen <= '0;
                r_kept <= '0;
            end

            if (r_state == ppdf_pkg::S_CHECK) begin
                r_dup <= 1'b0;
            end else if (r_vld[ppdf_pkg::PIPE_LAT-1] && w_hit) begin
                r_dup <= 1'b1;
            end

            if (w_commit) begin
                r_seen <= r_seen + CW'(1);
                if (!r_off && !r_dup) begin
                    r_kept <= r_kept + CW'(1);
                end
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_tol_sq <= r_tol * r_tol;

        if (w_accept) begin
            r_probe.x <= i_pt.coord_x;
            r_probe.y <= i_pt.coord_y;
            r_probe.z <= i_pt.coord_z;
            r_part    <= i_pt.source_part;
            r_index   <= i_pt.local_index;
        end

        if (r_state == ppdf_pkg::S_CHECK) begin
            r_off     <= w_off;
            r_addr    <= '0;
            r_status  <= ppdf_pkg::ST_FULL;
            r_ordinal <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + AW'(1);
        end

        if (w_commit) begin
            if (r_off) begin
                r_status  <= ppdf_pkg::ST_OFF_PLANE;
                r_ordinal <= '0;
            end else if (r_dup) begin
                r_status  <= ppdf_pkg::ST_DUPLICATE;
                r_ordinal <= '0;
            end else begin
                r_status  <= ppdf_pkg::ST_KEPT;
                r_ordinal <= ppdf_pkg::t_ordinal'(r_kept);
            end
        end

        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_ord    <= r_ordinal;
            r_out_part   <= r_part;
            r_out_index  <= r_index;
        end
    end

    // ---------------------------------------------------------------
    // Point store
    // ---------------------------------------------------------------
    ppdf_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_commit),
        .i_waddr (r_seen[AW-1:0]),
        .i_wdata (r_probe),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_stored_pt = ppdf_pkg::t_point'(w_rdata);

    // stagger y and z so each cell meets its left neighbor's sum
    always_ff @(posedge i_clk) begin
        r_y_d1 <= w_stored_pt.y;
        r_z_d1 <= w_stored_pt.z;
        r_z_d2 <= r_z_d1;
    end

    assign w_stored[0] = w_stored_pt.x;
    assign w_stored[1] = r_y_d1;
    assign w_stored[2] = r_z_d2;
    assign w_probe[0]  = r_probe.x;
    assign w_probe[1]  = r_probe.y;
    assign w_probe[2]  = r_probe.z;
    assign w_chain[0]  = '0;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        ppdf_cell u_cell (
            .i_clk    (i_clk),
            .i_stored (w_stored[k]),
            .i_probe  (w_probe[k]),
            .i_tol    (r_tol),
            .i_part   (w_chain[k]),
            .o_part   (w_chain[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign i_pt.ready         = w_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.kept_ordinal = r_out_ord;
    assign o_res.out_part     = r_out_part;
    assign o_res.out_index    = r_out_index;

endmodule

/* rtl/ppdf_chk.sv */
`timescale 1ns / 1ps

module ppdf_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_pt_valid,
    input logic                               i_pt_ready,
    input logic                               i_res_valid,
    input logic                               i_res_ready,
    input logic [1:0]                         i_res_status,
    input logic [ppdf_pkg::ORD_W-1:0]         i_res_ord,
    input logic [ppdf_pkg::PART_W-1:0]        i_res_part,
    input logic [ppdf_pkg::INDEX_W-1:0]       i_res_index
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable({i_res_status, i_res_ord, i_res_part, i_res_index}))
        else $error("result changed while stalled");

    // only kept points carry an ordinal
    a_ord_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status != ppdf_pkg::ST_KEPT) |-> (i_res_ord == '0))
        else $error("ordinal on a point that was not kept");

    // one point at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt_valid && i_pt_ready |=> !i_pt_ready)
        else $error("point accepted while another is in work");

endmodule

bind plane_point_dedup_filter ppdf_chk u_ppdf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pt_valid   (i_pt.valid),
    .i_pt_ready   (i_pt.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_ord    (o_res.kept_ordinal),
    .i_res_part   (o_res.out_part),
    .i_res_index  (o_res.out_index)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the plane point dedup filter.
// Two parts, both checked by the same monitor:
//   1. A table of directed points and register writes. It covers the reset
//      settings, plane boundaries, coordinate extremes, zero and full-scale
//      tolerance, and clearing with start_cloud.
//   2. Eight phases of random clouds. Each phase has its own plane_z and
//      match_tolerance, extremes among them.
// The sender works in bursts and the receiver stalls on a pattern of its own.
module testbench;

    localparam int               MAX_PTS     = 1024;
    localparam int               LIMIT_CYC   = 3_000_000;
    localparam int               PHASES      = 8;
    localparam int               PHASE_ITEMS = 72;
    localparam ppdf_pkg::t_coord CMAX        = 32'sh7FFF_FFFF;
    localparam ppdf_pkg::t_coord CMIN        = 32'sh8000_0000;

    typedef struct packed {
        logic                          start;
        ppdf_pkg::t_coord              x;
        ppdf_pkg::t_coord              y;
        ppdf_pkg::t_coord              z;
        logic [ppdf_pkg::PART_W-1:0]   part;
        logic [ppdf_pkg::INDEX_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        ppdf_pkg::t_status             st;
        ppdf_pkg::t_ordinal            ord;
        logic [ppdf_pkg::PART_W-1:0]   part;
        logic [ppdf_pkg::INDEX_W-1:0]  idx;
    } t_verdict;

    typedef enum logic {
        ROW_POINT,
        ROW_SETTING
    } t_row_kind;

    // A setting row carries plane_z in item.x and the tolerance word in item.y.
    typedef struct packed {
        t_row_kind          kind;
        t_item              item;
        logic               typed;
        ppdf_pkg::t_status  st;
        ppdf_pkg::t_ordinal ord;
    } t_row;

    // Directed table. Rows with typed = 1 carry a status and an ordinal that
    // can be read straight off the rules. All other rows go to the predictor.
    t_row dir_rows [27] = '{
        // reset settings: plane_z = 0, tolerance = 66
        '{ROW_POINT, '{1'b1, 32'sd0, 32'sd0, 32'sd0, 8'h00, 16'h0000}, 1'b1,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, 32'sd66, 8'h01, 16'h0001}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, 32'sd67, 8'h02, 16'h0002}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, -32'sd67, 8'h03, 16'h0003}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd10, 32'sd10, 32'sd10, 8'h04, 16'h0004}, 1'b1,
          ppdf_pkg::ST_DUPLICATE, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd65, 32'sd0, -32'sd66, 8'h05, 16'h0005}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, CMAX, CMIN, 32'sd0, 8'hFF, 16'hFFFF}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, CMIN, CMAX, -32'sd66, 8'hAA, 16'h5555}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, CMAX, CMIN, 32'sd0, 8'h55, 16'hAAAA}, 1'b1,
          ppdf_pkg::ST_DUPLICATE, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, CMAX, 8'h06, 16'h0006}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, CMIN, 8'h07, 16'h0007}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b1, 32'sd0, 32'sd0, 32'sd0, 8'h3C, 16'hC3C3}, 1'b1,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, 32'sd0, 8'h08, 16'h0008}, 1'b1,
          ppdf_pkg::ST_DUPLICATE, 10'd0},
        // zero tolerance: identical points are both kept
        '{ROW_SETTING, '{1'b0, 32'sd0, 32'sd0, 32'sd0, 8'h00, 16'h0000}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b1, 32'sd5, 32'sd5, 32'sd0, 8'h09, 16'h0009}, 1'b1,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd5, 32'sd5, 32'sd0, 8'h0A, 16'h000A}, 1'b1,
          ppdf_pkg::ST_KEPT, 10'd1},
        '{ROW_POINT, '{1'b0, 32'sd5, 32'sd5, 32'sd1, 8'h0B, 16'h000B}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        // most negative plane, full-scale tolerance
        '{ROW_SETTING, '{1'b0, CMIN, CMAX, 32'sd0, 8'h00, 16'h0000}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b1, 32'sd0, 32'sd0, -32'sd1, 8'h0C, 16'h000C}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, 32'sd0, 8'h0D, 16'h000D}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b0, CMAX, CMAX, CMAX, 8'h0E, 16'h000E}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0},
        '{ROW_POINT, '{1'b0, CMIN, CMIN, CMIN, 8'h0F, 16'h000F}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd1000, -32'sd1000, -32'sd5, 8'h10, 16'h0010}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        // most positive plane; bit 31 of the tolerance word must be dropped
        '{ROW_SETTING, '{1'b0, CMAX, 32'shFFFF_FFFF, 32'sd0, 8'h00, 16'h0000}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b1, 32'sd0, 32'sd0, CMAX, 8'h11, 16'h0011}, 1'b1,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, 32'sd0, 8'h12, 16'h0012}, 1'b0,
          ppdf_pkg::ST_KEPT, 10'd0},
        '{ROW_POINT, '{1'b0, 32'sd0, 32'sd0, -32'sd1, 8'h13, 16'h0013}, 1'b1,
          ppdf_pkg::ST_OFF_PLANE, 10'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [ppdf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ppdf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ppdf_pt_if  pt ();
    ppdf_res_if res ();

    plane_point_dedup_filter #(
        .MAX_POINTS(MAX_PTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt),
        .o_res      (res)
    );

    // Mirror of the block: register copies, the point store and both counts.
    ppdf_pkg::t_coord   plane_z_reg;
    ppdf_pkg::t_tol     tol_reg;
    ppdf_pkg::t_point   cloud_pts [MAX_PTS];
    int                 cloud_cnt;
    int                 kept_cnt;

    // Verdicts of accepted points, oldest first.
    t_verdict verdict_q [$];
    t_verdict head_v;

    int fail_cnt;
    int n_points;
    int n_settings;
    int n_kept;
    int n_off;
    int n_dup;
    int n_full;
    int burst_left;
    int rx_mode;
    int rx_left;
    int cyc_cnt;

    always #5 i_clk = ~i_clk;

    // Distance along one axis, exact, never negative.
    function automatic longint axis_gap(ppdf_pkg::t_coord a, ppdf_pkg::t_coord b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    // Squared distance strictly below tol squared. Any axis at or beyond tol
    // rules the pair out first, so the sum of squares stays below 2^64.
    function automatic bit close_pair(ppdf_pkg::t_point a, ppdf_pkg::t_point b,
                                      ppdf_pkg::t_tol tol);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned dz;
        longint unsigned tl;
        dx = axis_gap(a.x, b.x);
        dy = axis_gap(a.y, b.y);
        dz = axis_gap(a.z, b.z);
        tl = tol;
        if (dx >= tl || dy >= tl || dz >= tl)
            return 1'b0;
        return (dx * dx + dy * dy + dz * dz) < (tl * tl);
    endfunction

    // Classify one accepted point and advance the mirrored store.
    function automatic t_verdict judge_point(t_item it);
        t_verdict         v;
        ppdf_pkg::t_point p;
        v.st   = ppdf_pkg::ST_KEPT;
        v.ord  = '0;
        v.part = it.part;
        v.idx  = it.idx;
        p      = '{it.x, it.y, it.z};
        if (it.start) begin
            cloud_cnt = 0;
            kept_cnt  = 0;
        end
        if (cloud_cnt >= MAX_PTS) begin
            // store full: nothing is tested, stored or counted
            v.st = ppdf_pkg::ST_FULL;
        end else begin
            if (axis_gap(it.z, plane_z_reg) > longint'(tol_reg)) begin
                v.st = ppdf_pkg::ST_OFF_PLANE;
            end else begin
                // compare against every stored point, off-plane ones included
                for (int i = 0; i < cloud_cnt && v.st == ppdf_pkg::ST_KEPT; i++) begin
                    if (close_pair(cloud_pts[i], p, tol_reg))
                        v.st = ppdf_pkg::ST_DUPLICATE;
                end
            end
            cloud_pts[cloud_cnt] = p;
            cloud_cnt++;
            if (v.st == ppdf_pkg::ST_KEPT) begin
                v.ord = ppdf_pkg::t_ordinal'(kept_cnt);
                kept_cnt++;
            end
        end
        return v;
    endfunction

    // Uniform value in [-lim, lim].
    function automatic longint spread(longint lim);
        longint unsigned r;
        longint unsigned span;
        if (lim <= 0)
            return 0;
        r    = {$urandom(), $urandom()};
        span = 2 * lim + 1;
        return longint'(r % span) - lim;
    endfunction

    // Offer one point and hold it until the block takes it. Between bursts,
    // drop valid for a random gap; some gaps are zero, so long stretches run
    // without idling. Valid is never lowered and raised in the same step.
    task automatic offer_point(input t_item it, input logic typed,
                               input ppdf_pkg::t_status st, input ppdf_pkg::t_ordinal ord);
        int       gap;
        t_verdict v;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                pt.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        pt.valid       <= 1'b1;
        pt.start_cloud <= it.start;
        pt.coord_x     <= it.x;
        pt.coord_y     <= it.y;
        pt.coord_z     <= it.z;
        pt.source_part <= it.part;
        pt.local_index <= it.idx;
        do @(posedge i_clk); while (!pt.ready);
        // transaction accepted at this edge
        v = judge_point(it);
        if (typed) begin
            v.st  = st;
            v.ord = ord;
        end
        verdict_q.push_back(v);
        n_points++;
    endtask

    // Hold the sender until every verdict is in, then let the pipeline empty.
    task automatic settle();
        pt.valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (ppdf_pkg::PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Write plane_z, then match_tolerance, on back-to-back edges.
    task automatic apply_setting(input ppdf_pkg::t_coord pl,
                                 input logic [ppdf_pkg::CFG_DATA_W-1:0] tl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ppdf_pkg::CFG_PLANE_Z;
        i_cfg_data <= pl;
        @(posedge i_clk);
        i_cfg_idx  <= ppdf_pkg::CFG_MATCH_TOL;
        i_cfg_data <= tl;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        plane_z_reg = pl;
        tol_reg     = tl[ppdf_pkg::TOL_W-1:0];
        n_settings++;
    endtask

    // Receiver: alternate between always ready, mostly ready and mostly
    // stalled, each mode held for a random number of cycles.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(5, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= ($urandom_range(0, 2) != 0);
            default: res.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare every result transaction with the oldest verdict.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (verdict_q.size() == 0) begin
                $error("result with no point waiting: part %0d index %0d",
                       res.out_part, res.out_index);
                fail_cnt++;
            end else begin
                head_v = verdict_q.pop_front();
                if (res.status !== head_v.st) begin
                    $error("status: expected %0d, got %0d", head_v.st, res.status);
                    fail_cnt++;
                end
                if (res.kept_ordinal !== head_v.ord) begin
                    $error("kept_ordinal: expected %0d, got %0d", head_v.ord,
                           res.kept_ordinal);
                    fail_cnt++;
                end
                if (res.out_part !== head_v.part) begin
                    $error("out_part: expected %0d, got %0d", head_v.part, res.out_part);
                    fail_cnt++;
                end
                if (res.out_index !== head_v.idx) begin
                    $error("out_index: expected %0d, got %0d", head_v.idx, res.out_index);
                    fail_cnt++;
                end
                case (head_v.st)
                    ppdf_pkg::ST_KEPT:      n_kept++;
                    ppdf_pkg::ST_OFF_PLANE: n_off++;
                    ppdf_pkg::ST_DUPLICATE: n_dup++;
                    default:                n_full++;
                endcase
            end
        end
    end

    // Watchdog. A verdict that never arrives ends up here too, since the
    // final settle waits for an empty queue.
    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYC) begin
            $display("run stopped after %0d cycles, %0d verdicts still waiting",
                     cyc_cnt, verdict_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_item             it;
        ppdf_pkg::t_point  hp;
        ppdf_pkg::t_point  cloud_hist [$];
        ppdf_pkg::t_coord  pl;
        logic [31:0]       tl;
        longint            p;
        longint            t;
        longint            lim;
        longint            bx;
        longint            by;
        longint            zo;
        int                cloud_left;
        int                sel;
        int                zsel;

        // Drive every input to a known value from time zero.
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = ppdf_pkg::CFG_PLANE_Z;
        i_cfg_data     = '0;
        pt.valid       = 1'b0;
        pt.start_cloud = 1'b0;
        pt.coord_x     = '0;
        pt.coord_y     = '0;
        pt.coord_z     = '0;
        pt.source_part = '0;
        pt.local_index = '0;
        res.ready      = 1'b0;
        plane_z_reg    = '0;
        tol_reg        = ppdf_pkg::TOL_RESET;
        cloud_cnt      = 0;
        kept_cnt       = 0;
        fail_cnt       = 0;
        n_points       = 0;
        n_settings     = 0;
        n_kept         = 0;
        n_off          = 0;
        n_dup          = 0;
        n_full         = 0;
        burst_left     = 0;
        rx_mode        = 0;
        rx_left        = 0;
        cyc_cnt        = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Setting rows wait for the block to go idle first.
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_SETTING) begin
                settle();
                apply_setting(dir_rows[k].item.x, dir_rows[k].item.y);
            end else begin
                offer_point(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].st,
                            dir_rows[k].ord);
            end
        end

        // Random clouds. Most points sit near a cloud center, on the plane or
        // just past its edge, so duplicates and boundary hits are frequent. The
        // rest are pure noise or reuse x and y of an earlier point, half with its z.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin pl = '0;        tl = 32'd66;                              end
                1: begin pl = $urandom;  tl = $urandom_range(1, 4096);             end
                2: begin pl = CMIN;      tl = $urandom_range(1 << 24, 1 << 30);    end
                3: begin pl = CMAX;      tl = 32'd0;                               end
                4: begin pl = $urandom;  tl = 32'h7FFF_FFFF;                       end
                5: begin pl = $urandom;  tl = $urandom_range(1, 200) | 32'h8000_0000; end
                6: begin pl = $urandom;  tl = $urandom_range(1, 1 << 20);          end
                default: begin pl = $urandom; tl = $urandom;                       end
            endcase
            settle();
            apply_setting(pl, tl);
            p          = plane_z_reg;
            t          = tol_reg;
            lim        = (t == 0) ? 2 : ((2 * t > 64'h1_0000_0000) ? 64'h1_0000_0000 : 2 * t);
            cloud_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel      = $urandom_range(0, 99);
                it.start = 1'b0;
                if (cloud_left == 0 || sel < 3) begin
                    // open a new cloud around a fresh center
                    it.start = 1'b1;
                    cloud_hist.delete();
                    bx = longint'(ppdf_pkg::t_coord'($urandom));
                    by = longint'(ppdf_pkg::t_coord'($urandom));
                    cloud_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 25);
                end
                cloud_left--;
                zsel = $urandom_range(0, 9);
                case (zsel)
                    0: zo = t + 1;
                    1: zo = -t - 1;
                    2: zo = t;
                    3: zo = -t;
                    default: zo = spread(t);
                endcase
                if (sel < 15) begin
                    it.x = $urandom;
                    it.y = $urandom;
                    it.z = $urandom;
                end else if (sel < 27 && cloud_hist.size() != 0) begin
                    hp   = cloud_hist[$urandom_range(0, cloud_hist.size() - 1)];
                    it.x = hp.x;
                    it.y = hp.y;
                    it.z = $urandom_range(0, 1) ? hp.z : ppdf_pkg::t_coord'(p + zo);
                end else begin
                    it.x = ppdf_pkg::t_coord'(bx + spread(lim));
                    it.y = ppdf_pkg::t_coord'(by + spread(lim));
                    it.z = ppdf_pkg::t_coord'(p + zo);
                end
                it.part = $urandom;
                it.idx  = $urandom;
                offer_point(it, 1'b0, ppdf_pkg::ST_KEPT, '0);
                hp = '{it.x, it.y, it.z};
                cloud_hist.push_back(hp);
            end
        end

        // Drain and finish.
        settle();
        repeat (ppdf_pkg::PIPE_LAT + 10) @(posedge i_clk);

        $display("Covered %0d points over %0d register settings, directed and random.",
                 n_points, n_settings);
        $display("Verdicts: %0d kept, %0d off plane, %0d duplicate, %0d store full.",
                 n_kept, n_off, n_dup, n_full);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
